FILE: src/sep_pkg.sv
// ============================================================================
// sep_pkg
// shared types, constants and command/status structs for the edge partitioner
// ============================================================================
package sep_pkg;

    localparam int DEF_WORKERS   = 16;
    localparam int DEF_VERTICES  = 65536;
    localparam int DEF_LOAD_BITS = 32;

    localparam int VID_W = 16;
    localparam int OUT_W = 4;
    localparam int TOL_W = 10;
    localparam int CNT_W = 5;

    localparam logic [1:0] MODE_NAIVE  = 2'd0;
    localparam logic [1:0] MODE_HASH   = 2'd1;
    localparam logic [1:0] MODE_GREEDY = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_RD,
        ST_DECIDE,
        ST_CHARGE1,
        ST_CHARGE2,
        ST_SCAN,
        ST_THRESH,
        ST_OUT
    } sep_state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic hash_step;
        logic mem_read;
        logic decide;
        logic charge1;
        logic charge2;
        logic scan_start;
        logic scan_step;
        logic thresh;
        logic out_load;
    } sep_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic hash_done;
        logic need_scan;
        logic scan_done;
        logic need_charge2;
        logic thresh_done;
    } sep_stat_t;

endpackage

FILE: src/sep_ctrl.sv
// ============================================================================
// sep_ctrl
// sequencer: clear pass, hash, greedy lookup, charge, rescan, output
// ============================================================================
module sep_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         mode,
    input  logic               in_fire,
    input  logic               out_busy,
    input  sep_pkg::sep_stat_t stat,
    output sep_pkg::sep_cmd_t  cmd,
    output logic               in_ready
);
    import sep_pkg::*;

    sep_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (stat.clear_done) state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_fire) begin
                    if (mode == MODE_NAIVE) state_next = ST_OUT;
                    else if (mode == MODE_HASH) state_next = ST_HASH;
                    else state_next = ST_RD;
                end
            end
            ST_HASH:    if (stat.hash_done) state_next = ST_OUT;
            ST_RD:      state_next = ST_DECIDE;
            ST_DECIDE:  state_next = ST_CHARGE1;
            ST_CHARGE1: state_next = stat.need_charge2 ? ST_CHARGE2
                                   : (stat.need_scan ? ST_SCAN : ST_OUT);
            ST_CHARGE2: state_next = stat.need_scan ? ST_SCAN : ST_OUT;
            ST_SCAN:    if (stat.scan_done) state_next = ST_THRESH;
            ST_THRESH:  if (stat.thresh_done) state_next = ST_OUT;
            ST_OUT:     if (!out_busy) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:   cmd.clear_step = 1'b1;
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load_item = in_fire;
            end
            ST_HASH:    cmd.hash_step = 1'b1;
            ST_RD:      cmd.mem_read = 1'b1;
            ST_DECIDE:  cmd.decide = 1'b1;
            ST_CHARGE1: begin
                cmd.charge1 = 1'b1;
                cmd.scan_start = !stat.need_charge2 && stat.need_scan;
            end
            ST_CHARGE2: begin
                cmd.charge2 = 1'b1;
                cmd.scan_start = stat.need_scan;
            end
            ST_SCAN:    cmd.scan_step = 1'b1;
            ST_THRESH:  cmd.thresh = 1'b1;
            ST_OUT:     cmd.out_load = !out_busy;
            default:    cmd = '0;
        endcase
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.charge1, cmd.charge2, cmd.scan_step, cmd.out_load, cmd.decide}))
        else $error("overlapping datapath commands");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !cmd.out_load && !cmd.scan_step)
        else $error("ready while busy");
    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !in_ready)
        else $error("input taken during clear");

endmodule

FILE: src/sep_dp.sv
// ============================================================================
// sep_dp
// datapath: owner table, load registers, min tracking, hash remainder
// ============================================================================
module sep_dp #(
    parameter int WORKERS   = sep_pkg::DEF_WORKERS,
    parameter int VERTICES  = sep_pkg::DEF_VERTICES,
    parameter int LOAD_BITS = sep_pkg::DEF_LOAD_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sep_pkg::sep_cmd_t         cmd,
    input  logic [sep_pkg::VID_W-1:0] src_vertex,
    input  logic [sep_pkg::VID_W-1:0] dst_vertex,
    input  logic [1:0]                mode,
    input  logic [sep_pkg::CNT_W-1:0] worker_count,
    input  logic [sep_pkg::TOL_W-1:0] tolerance_q8,
    output sep_pkg::sep_stat_t        stat,
    output logic [sep_pkg::OUT_W-1:0] src_worker,
    output logic [sep_pkg::OUT_W-1:0] dst_worker,
    output logic                      broadcast
);
    import sep_pkg::*;

    localparam int WW  = $clog2(WORKERS);
    localparam int AW  = $clog2(VERTICES);
    localparam int NW  = $clog2(WORKERS + 1);
    localparam int THW = LOAD_BITS + 11;
    localparam logic [LOAD_BITS-1:0] LMAX = '1;
    localparam int MW  = (NW > CNT_W) ? NW : CNT_W;

    // owner table: worker + 1, zero means unassigned
    logic [WW:0] owner_mem [VERTICES];
    logic [WW:0] so_reg, do_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_done_reg;

    logic [LOAD_BITS-1:0] load_reg [WORKERS];
    logic [WW-1:0]        minw_reg;
    logic [LOAD_BITS-1:0] minl_reg;
    logic [THW-1:0]       thr_reg;

    logic [VID_W-1:0] src_reg, dst_reg;
    logic [WW-1:0]    w1_reg, w2_reg;
    logic             bc_reg;
    logic [NW-1:0]    scan_i_reg;
    logic [NW-1:0]    n_eff;

    // hash remainders by restoring shift-subtract, one bit per cycle
    logic [VID_W-1:0] hq1_reg, hq2_reg;
    logic [NW-1:0]    hr1_reg, hr2_reg;
    logic [4:0]       hcnt_reg;

    // threshold multiply by shift-add over the 10 tolerance bits
    logic [THW-1:0]   tacc_reg;
    logic [3:0]       tcnt_reg;

    logic [AW-1:0] si, di;
    assign si = AW'(src_reg);
    assign di = AW'(dst_reg);

    always_comb begin
        logic [MW-1:0] c;
        c = MW'(worker_count);
        if (c == '0) n_eff = NW'(1);
        else if (c > MW'(WORKERS)) n_eff = NW'(WORKERS);
        else n_eff = NW'(c);
    end

    // decide combinational
    logic so_v, do_v;
    logic [WW-1:0] sw, dw, d1, d2;
    logic tol_s, tol_d;
    assign so_v = so_reg != '0;
    assign do_v = do_reg != '0;
    assign sw = WW'(so_reg - 1'b1);
    assign dw = WW'(do_reg - 1'b1);
    assign tol_s = {3'b0, load_reg[sw], 8'b0} <= thr_reg;
    assign tol_d = {3'b0, load_reg[dw], 8'b0} <= thr_reg;
    always_comb begin
        d1 = minw_reg;
        d2 = minw_reg;
        if (!so_v && do_v) begin
            d2 = dw;
            d1 = tol_d ? dw : minw_reg;
        end else if (so_v && !do_v) begin
            d1 = sw;
            d2 = tol_s ? sw : minw_reg;
        end else if (so_v && do_v) begin
            d1 = sw;
            d2 = dw;
        end
    end

    logic [NW:0] hs1, hs2;
    assign hs1 = {hr1_reg, hq1_reg[VID_W-1]} - {1'b0, n_eff};
    assign hs2 = {hr2_reg, hq2_reg[VID_W-1]} - {1'b0, n_eff};

    assign stat.clear_done   = clr_done_reg;
    assign stat.hash_done    = hcnt_reg == 5'd1;
    assign stat.need_charge2 = w2_reg != w1_reg;
    assign stat.need_scan    = (w1_reg == minw_reg) || (w2_reg == minw_reg);
    assign stat.scan_done    = scan_i_reg >= n_eff;
    assign stat.thresh_done  = tcnt_reg == 4'd0;

    // table write / read
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            owner_mem[clr_addr_reg] <= '0;
        end else if (cmd.decide) begin
            if (!so_v) owner_mem[si] <= {1'b0, d1} + 1'b1;
            if (!do_v && !(so_v == 1'b0 && si == di)) owner_mem[di] <= {1'b0, d2} + 1'b1;
        end
        if (cmd.mem_read) begin
            so_reg <= owner_mem[si];
            do_reg <= owner_mem[di];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else if (cmd.clear_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(VERTICES - 1)) clr_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORKERS; i++) load_reg[i] <= '0;
            minw_reg   <= '0;
            minl_reg   <= '0;
            thr_reg    <= '0;
            hcnt_reg   <= '0;
            tcnt_reg   <= '0;
            scan_i_reg <= '0;
        end else begin
            if (cmd.load_item) begin
                src_reg  <= src_vertex;
                dst_reg  <= dst_vertex;
                hq1_reg  <= src_vertex;
                hq2_reg  <= dst_vertex;
                hr1_reg  <= '0;
                hr2_reg  <= '0;
                hcnt_reg <= 5'(VID_W);
                w1_reg   <= '0;
                w2_reg   <= '0;
            end
            if (cmd.hash_step) begin
                hq1_reg <= hq1_reg << 1;
                hq2_reg <= hq2_reg << 1;
                hr1_reg <= hs1[NW] ? {hr1_reg[NW-2:0], hq1_reg[VID_W-1]} : hs1[NW-1:0];
                hr2_reg <= hs2[NW] ? {hr2_reg[NW-2:0], hq2_reg[VID_W-1]} : hs2[NW-1:0];
                hcnt_reg <= hcnt_reg - 1'b1;
                if (hcnt_reg == 5'd1) begin
                    w1_reg <= WW'(hs1[NW] ? {hr1_reg[NW-2:0], hq1_reg[VID_W-1]}
                                          : hs1[NW-1:0]);
                    w2_reg <= WW'(hs2[NW] ? {hr2_reg[NW-2:0], hq2_reg[VID_W-1]}
                                          : hs2[NW-1:0]);
                end
            end
            if (cmd.decide) begin
                w1_reg <= d1;
                w2_reg <= d2;
            end
            if (cmd.charge1 && load_reg[w1_reg] != LMAX)
                load_reg[w1_reg] <= load_reg[w1_reg] + 1'b1;
            if (cmd.charge2 && load_reg[w2_reg] != LMAX)
                load_reg[w2_reg] <= load_reg[w2_reg] + 1'b1;
            if (cmd.scan_start) begin
                scan_i_reg <= '0;
            end
            if (cmd.scan_step) begin
                if (scan_i_reg == '0) begin
                    minl_reg <= load_reg[minw_reg];
                    if (load_reg[0] < load_reg[minw_reg]) begin
                        minl_reg <= load_reg[0];
                        minw_reg <= '0;
                    end
                    scan_i_reg <= NW'(1);
                end else if (scan_i_reg < n_eff) begin
                    if (load_reg[WW'(scan_i_reg)] < minl_reg) begin
                        minl_reg <= load_reg[WW'(scan_i_reg)];
                        minw_reg <= WW'(scan_i_reg);
                    end
                    scan_i_reg <= scan_i_reg + 1'b1;
                end
                if (scan_i_reg >= n_eff) begin
                    tacc_reg <= THW'(minl_reg) << 8;
                    tcnt_reg <= 4'd10;
                end
            end
            if (cmd.thresh && tcnt_reg != 4'd0) begin
                if (tolerance_q8[4'd10 - tcnt_reg])
                    tacc_reg <= tacc_reg + (THW'(minl_reg) << (4'd10 - tcnt_reg));
                tcnt_reg <= tcnt_reg - 1'b1;
            end
            if (cmd.thresh && tcnt_reg == 4'd0) thr_reg <= tacc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            src_worker <= (mode == MODE_NAIVE) ? '0 : OUT_W'(w1_reg);
            dst_worker <= (mode == MODE_NAIVE) ? '0 : OUT_W'(w2_reg);
            bc_reg     <= (mode == MODE_NAIVE) || (w1_reg != w2_reg);
        end
    end
    assign broadcast = bc_reg;

    a_min_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (32'(minw_reg) < WORKERS))
        else $error("min worker out of range");
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.charge1 && load_reg[w1_reg] == LMAX |=> load_reg[$past(w1_reg)] == LMAX)
        else $error("load wrapped");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_done_reg |=> !cmd.clear_step)
        else $error("clear ran past end");

endmodule

FILE: src/streaming_edge_partitioner.sv
// ============================================================================
// streaming_edge_partitioner
// assigns each streamed edge to one or two workers (naive, hash, greedy)
// ============================================================================
// usage:
//  - s_axis carries one edge per transaction; m_axis returns one result
//  - cfg_we/cfg_addr/cfg_wdata write mode, worker_count, tolerance_q8 when idle
//  - after reset the owner table is cleared, one entry per cycle, and
//    s_axis_tready stays low meanwhile
//  - naive mode: no lookup; hash mode: a bit-serial remainder of each vertex
//    by the clamped worker_count, one vertex bit per cycle
//  - greedy mode: owner read, decide and one or two charge steps; a rescan
//    adds the compare loop over the clamped worker_count plus the
//    shift-add threshold multiplier
//  - the result sits in an output register; a stalled receiver holds it and
//    the block takes the next edge meanwhile, then waits in its last step
//    until the output register is free again
// ============================================================================
module streaming_edge_partitioner #(
    parameter int WORKERS   = sep_pkg::DEF_WORKERS,
    parameter int VERTICES  = sep_pkg::DEF_VERTICES,
    parameter int LOAD_BITS = sep_pkg::DEF_LOAD_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // src_vertex[15:0], dst_vertex[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // src_worker[3:0], dst_worker[7:4], broadcast[8]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata
);
    import sep_pkg::*;

    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [TOL_W-1:0] tol_reg;
    logic             mvalid_reg;
    sep_cmd_t  cmd;
    sep_stat_t stat;
    logic [OUT_W-1:0] sw, dw;
    logic bc;
    logic in_fire;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_GREEDY;
            count_reg <= CNT_W'(16);
            tol_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODE:  mode_reg  <= cfg_wdata[1:0];
                REG_COUNT: count_reg <= cfg_wdata[CNT_W-1:0];
                REG_TOL:   tol_reg   <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    sep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mode     (mode_reg),
        .in_fire  (in_fire),
        .out_busy (mvalid_reg && !m_axis_tready),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    sep_dp #(
        .WORKERS   (WORKERS),
        .VERTICES  (VERTICES),
        .LOAD_BITS (LOAD_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .src_vertex   (s_axis_tdata[15:0]),
        .dst_vertex   (s_axis_tdata[31:16]),
        .mode         (mode_reg),
        .worker_count (count_reg),
        .tolerance_q8 (tol_reg),
        .stat         (stat),
        .src_worker   (sw),
        .dst_worker   (dw),
        .broadcast    (bc)
    );

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {7'b0, bc, dw, sw};

endmodule
